[rtl/core/udq_pkg.sv]
// ----------------------------------------------------------------------------
// udq_pkg
// Types and constants shared by the URL percent decoder and query splitter.
// ----------------------------------------------------------------------------
package udq_pkg;

    localparam int MAX_DECODED = 256;
    localparam int CNT_W       = $clog2(MAX_DECODED + 1);
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QMARK = 8'h3F;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_PATH  = 2'd1,
        KIND_NAME  = 2'd2,
        KIND_VALUE = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [1:0] token_kind;
        logic       is_char;
        logic [7:0] out_char;
        logic       token_end;
        logic       end_of_string;
    } t_res;

    typedef struct packed {
        logic [1:0] n;
        t_res       r0;
        t_res       r1;
    } t_push;

endpackage

[rtl/core/udq_core.sv]
// ----------------------------------------------------------------------------
// udq_core
// Percent decoder and token splitter state; produces up to two results
// for each byte transferred.
// ----------------------------------------------------------------------------
module udq_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  udq_pkg::t_in  i_item,
    output udq_pkg::t_push o_push
);
    import udq_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_HIGH = 3'b010,
        PH_LOW  = 3'b100
    } t_phase;

    typedef enum logic [3:0] {
        MODE_WAIT  = 4'b0001,
        MODE_PATH  = 4'b0010,
        MODE_NAME  = 4'b0100,
        MODE_VALUE = 4'b1000
    } t_mode;

    function automatic logic [7:0] hex_val(input logic [7:0] b);
        logic [7:0] v;
        if (b inside {[8'h30:8'h39]}) begin
            v = b - 8'h30;
        end else if (b inside {[8'h41:8'h46]}) begin
            v = b - 8'h37;
        end else if (b inside {[8'h61:8'h66]}) begin
            v = b - 8'h57;
        end else begin
            v = b;
        end
        return v;
    endfunction

    function automatic t_kind kind_of(input t_mode m);
        t_kind k;
        case (m)
            MODE_PATH:  k = KIND_PATH;
            MODE_NAME:  k = KIND_NAME;
            MODE_VALUE: k = KIND_VALUE;
            default:    k = KIND_NONE;
        endcase
        return k;
    endfunction

    t_phase             r_phase, n_phase;
    logic [7:0]         r_high, n_high;
    t_mode              r_mode, n_mode;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_done, n_done;

    logic       ended, have, split_emit, end_emit;
    logic [7:0] c, hv, b;
    t_res       split_res, end_res;
    t_push      push;

    always_comb begin
        b          = i_item.in_byte;
        hv         = hex_val(b);
        n_phase    = r_phase;
        n_high     = r_high;
        n_mode     = r_mode;
        n_cnt      = r_cnt;
        n_done     = r_done;
        ended      = 1'b0;
        have       = 1'b0;
        c          = CH_NUL;
        split_emit = 1'b0;
        end_emit   = 1'b0;
        split_res  = '0;
        end_res    = '0;
        push       = '0;

        if (!r_done) begin
            if (b == CH_NUL) begin
                ended = 1'b1;
            end else begin
                case (r_phase)
                    PH_IDLE: begin
                        if (b == CH_PCT) begin
                            n_phase = PH_HIGH;
                        end else begin
                            c    = b;
                            have = 1'b1;
                        end
                    end
                    PH_HIGH: begin
                        n_high  = hv;
                        n_phase = PH_LOW;
                    end
                    default: begin
                        c       = {r_high[3:0], 4'h0} + hv;
                        n_phase = PH_IDLE;
                        have    = 1'b1;
                    end
                endcase
            end

            if (have) begin
                if (c == CH_NUL) begin
                    ended = 1'b1;
                end else begin
                    split_res.token_kind = kind_of(r_mode);
                    case (r_mode)
                        MODE_PATH: begin
                            split_emit = 1'b1;
                            if (c == CH_QMARK) begin
                                split_res.token_end = 1'b1;
                                n_mode = MODE_NAME;
                            end else begin
                                split_res.is_char  = 1'b1;
                                split_res.out_char = c;
                            end
                        end
                        MODE_NAME: begin
                            split_emit = 1'b1;
                            if (c == CH_EQ) begin
                                split_res.token_end = 1'b1;
                                n_mode = MODE_VALUE;
                            end else begin
                                split_res.is_char  = 1'b1;
                                split_res.out_char = c;
                            end
                        end
                        MODE_VALUE: begin
                            split_emit = 1'b1;
                            if (c == CH_AMP) begin
                                split_res.token_end = 1'b1;
                                n_mode = MODE_NAME;
                            end else begin
                                split_res.is_char  = 1'b1;
                                split_res.out_char = c;
                            end
                        end
                        default: begin
                            if (c == CH_SLASH) begin
                                n_mode = MODE_PATH;
                            end
                        end
                    endcase
                    n_cnt = r_cnt + CNT_W'(1);
                    if (n_cnt >= CNT_W'(MAX_DECODED)) begin
                        ended = 1'b1;
                    end
                end
            end

            if (i_item.last) begin
                ended = 1'b1;
            end

            if (ended) begin
                n_phase = PH_IDLE;
                n_done  = 1'b1;
                if (n_mode != MODE_WAIT) begin
                    end_emit           = 1'b1;
                    end_res.token_kind = kind_of(n_mode);
                    end_res.token_end  = 1'b1;
                end
            end
        end

        if (split_emit) begin
            push.r0 = split_res;
            push.r1 = end_res;
            push.n  = end_emit ? 2'd2 : 2'd1;
        end else begin
            push.r0 = end_res;
            push.n  = end_emit ? 2'd1 : 2'd0;
        end

        if (i_item.last) begin
            if (push.n == 2'd0) begin
                push.r0 = '0;
                push.n  = 2'd1;
            end
            if (push.n == 2'd2) begin
                push.r1.end_of_string = 1'b1;
            end else begin
                push.r0.end_of_string = 1'b1;
            end
            n_phase = PH_IDLE;
            n_high  = '0;
            n_mode  = MODE_WAIT;
            n_cnt   = '0;
            n_done  = 1'b0;
        end

        if (!i_fire) begin
            push.n = 2'd0;
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_high  <= '0;
            r_mode  <= MODE_WAIT;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_high  <= n_high;
            r_mode  <= n_mode;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

endmodule

[rtl/core/udq_out_fifo.sv]
// ----------------------------------------------------------------------------
// udq_out_fifo
// Result queue; takes up to two results a cycle, gives one per transfer.
// ----------------------------------------------------------------------------
module udq_out_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  udq_pkg::t_push i_push,
    output logic           o_room2,
    output logic           o_valid,
    input  logic           i_ready,
    output udq_pkg::t_res  o_data
);
    import udq_pkg::*;

    t_res                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wp, n_wp;
    logic [FIFO_AW-1:0]  r_rp, n_rp;
    logic [FIFO_CW-1:0]  r_cnt, n_cnt;
    logic                pop;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign pop     = o_valid && i_ready;
    assign o_room2 = (r_cnt <= FIFO_CW'(FIFO_DEPTH - 2));

    always_comb begin
        n_wp  = r_wp + FIFO_AW'(i_push.n);
        n_rp  = r_rp + FIFO_AW'(pop);
        n_cnt = r_cnt + FIFO_CW'(i_push.n) - FIFO_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[r_wp + FIFO_AW'(1)] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

[rtl/core/url_percent_decode_query_split.sv]
// ----------------------------------------------------------------------------
// url_percent_decode_query_split
// Decodes %XY escapes in a URL byte stream and splits it into path,
// argument name and argument value tokens.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                   payload
//  input     in   i_in_valid / o_in_ready     i_in_data  (t_in)
//  result    out  o_out_valid / i_out_ready   o_out_data (t_res)
//
//  One byte per cycle while o_in_ready is high; results are registered,
//  first one the cycle after. A byte gives up to two results; the 4-entry
//  result queue drains at most one per cycle, so two-result bytes slow input.
//  o_in_ready is high while the queue has room for two results.
//  Synchronous active-low reset clears the decoder and the queue.
// ----------------------------------------------------------------------------
module url_percent_decode_query_split (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  udq_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output udq_pkg::t_res o_out_data
);
    import udq_pkg::*;

    t_push push;
    logic  room2;
    logic  fire;

    assign o_in_ready = room2;
    assign fire       = i_in_valid && room2;

    udq_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (i_in_data),
        .o_push  (push)
    );

    udq_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room2 (room2),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

[rtl/core/udq_checker.sv]
// ----------------------------------------------------------------------------
// udq_checker
// Port-level checks for the URL decoder and splitter.
// ----------------------------------------------------------------------------
module udq_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input udq_pkg::t_res o_out_data
);
    import udq_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result valid dropped while stalled");

    a_char_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.is_char |->
            !o_out_data.token_end && o_out_data.token_kind != KIND_NONE
            && o_out_data.out_char != CH_NUL)
        else $error("bad character transfer");

    a_end_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.token_end |->
            !o_out_data.is_char && o_out_data.out_char == CH_NUL
            && o_out_data.token_kind != KIND_NONE)
        else $error("bad token end transfer");

    a_eos_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.end_of_string |->
            o_out_data.token_end
            || (o_out_data.token_kind == KIND_NONE && !o_out_data.is_char
                && o_out_data.out_char == CH_NUL))
        else $error("end of string on a character transfer");

endmodule

bind url_percent_decode_query_split udq_checker u_udq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

[test/tb_url_percent_decode_query_split.sv]
// ----------------------------------------------------------------------------
// tb_url_percent_decode_query_split
// Self-checking bench for the URL percent decoder and query splitter. Bytes
// are pushed through the input channel with random gaps. An in-bench model
// of the decoder predicts the token results for each transfer, and every
// result transfer is checked in order against those predictions. The
// receiver stalls at random, and once holds off long enough to back up the
// block.
// ----------------------------------------------------------------------------
module tb_url_percent_decode_query_split;
    timeunit 1ns;
    timeprecision 1ps;

    import udq_pkg::*;

    typedef enum logic [1:0] {
        ESC_NONE       = 2'd0,
        ESC_AFTER_PCT  = 2'd1,
        ESC_AFTER_HIGH = 2'd2
    } t_esc;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    t_in  in_data;
    logic out_valid;
    logic out_ready;
    t_res out_data;

    // decoder model state
    t_esc       esc      = ESC_NONE;
    logic [7:0] hi_nib   = '0;
    t_kind      mode     = KIND_NONE;
    int         dec_cnt  = 0;
    bit         str_done = 1'b0;

    t_res       tokens_due[$];
    logic [7:0] url_bytes[$];
    int         n_sent    = 0;
    int         n_fail    = 0;
    bit         tx_idle   = 1'b1;
    bit         rx_idle   = 1'b1;
    int         long_hold = 0;

    url_percent_decode_query_split u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------------
    function automatic logic [7:0] hex_val(input logic [7:0] b);
        if (b >= "0" && b <= "9") begin
            return b - "0";
        end
        if (b >= "A" && b <= "F") begin
            return b - "A" + 8'd10;
        end
        if (b >= "a" && b <= "f") begin
            return b - "a" + 8'd10;
        end
        return b;
    endfunction

    function automatic t_res make_token(input t_kind k, input logic ch_flag,
                                        input logic [7:0] c, input logic te);
        t_res r;
        r.token_kind    = k;
        r.is_char       = ch_flag;
        r.out_char      = c;
        r.token_end     = te;
        r.end_of_string = 1'b0;
        return r;
    endfunction

    function automatic bit split_char(input logic [7:0] c, output t_res r);
        r = '0;
        case (mode)
            KIND_NONE: begin
                if (c == CH_SLASH) begin
                    mode = KIND_PATH;
                end
                return 1'b0;
            end
            KIND_PATH: begin
                if (c == CH_QMARK) begin
                    r    = make_token(KIND_PATH, 1'b0, CH_NUL, 1'b1);
                    mode = KIND_NAME;
                end else begin
                    r = make_token(KIND_PATH, 1'b1, c, 1'b0);
                end
            end
            KIND_NAME: begin
                if (c == CH_EQ) begin
                    r    = make_token(KIND_NAME, 1'b0, CH_NUL, 1'b1);
                    mode = KIND_VALUE;
                end else begin
                    r = make_token(KIND_NAME, 1'b1, c, 1'b0);
                end
            end
            default: begin
                if (c == CH_AMP) begin
                    r    = make_token(KIND_VALUE, 1'b0, CH_NUL, 1'b1);
                    mode = KIND_NAME;
                end else begin
                    r = make_token(KIND_VALUE, 1'b1, c, 1'b0);
                end
            end
        endcase
        return 1'b1;
    endfunction

    function automatic void decode_and_split(input logic [7:0] b, input logic fin);
        t_res       made[$];
        t_res       r;
        logic [7:0] c;
        bit         have;
        bit         ended;
        have  = 1'b0;
        ended = 1'b0;
        c     = CH_NUL;
        if (!str_done) begin
            if (b == CH_NUL) begin
                ended = 1'b1;
            end else begin
                case (esc)
                    ESC_NONE: begin
                        if (b == CH_PCT) begin
                            esc = ESC_AFTER_PCT;
                        end else begin
                            c    = b;
                            have = 1'b1;
                        end
                    end
                    ESC_AFTER_PCT: begin
                        hi_nib = hex_val(b);
                        esc    = ESC_AFTER_HIGH;
                    end
                    default: begin
                        c    = {hi_nib[3:0], 4'h0} + hex_val(b);
                        esc  = ESC_NONE;
                        have = 1'b1;
                    end
                endcase
            end
            if (have) begin
                if (c == CH_NUL) begin
                    ended = 1'b1;
                end else begin
                    if (split_char(c, r)) begin
                        made.push_back(r);
                    end
                    dec_cnt++;
                    if (dec_cnt >= MAX_DECODED) begin
                        ended = 1'b1;
                    end
                end
            end
            if (fin) begin
                ended = 1'b1;
            end
            if (ended) begin
                esc = ESC_NONE;
                if (mode != KIND_NONE) begin
                    made.push_back(make_token(mode, 1'b0, CH_NUL, 1'b1));
                end
                str_done = 1'b1;
            end
        end
        if (fin) begin
            if (made.size() == 0) begin
                made.push_back(make_token(KIND_NONE, 1'b0, CH_NUL, 1'b0));
            end
            made[made.size() - 1].end_of_string = 1'b1;
            esc      = ESC_NONE;
            hi_nib   = '0;
            mode     = KIND_NONE;
            dec_cnt  = 0;
            str_done = 1'b0;
        end
        foreach (made[i]) begin
            tokens_due.push_back(made[i]);
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_url_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = tx_idle ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= t_in'{in_byte: b, last: fin};
        do @(posedge clk); while (in_ready !== 1'b1);
        decode_and_split(b, fin);
        n_sent++;
    endtask

    task automatic send_text(input string s, input bit fin);
        for (int i = 0; i < s.len(); i++) begin
            send_url_byte(s[i], fin && (i == s.len() - 1));
        end
    endtask

    task automatic send_url();
        for (int i = 0; i < url_bytes.size(); i++) begin
            send_url_byte(url_bytes[i], i == url_bytes.size() - 1);
        end
    endtask

    function automatic logic [7:0] hex_digit(input logic [3:0] d);
        if (d < 4'd10) begin
            return "0" + d;
        end
        return ($urandom_range(0, 1) ? "a" : "A") + d - 8'd10;
    endfunction

    function automatic void put_escape(input logic [7:0] v);
        url_bytes.push_back(CH_PCT);
        url_bytes.push_back(hex_digit(v[7:4]));
        url_bytes.push_back(hex_digit(v[3:0]));
    endfunction

    function automatic void put_content(input int n);
        logic [7:0] c;
        repeat (n) begin
            case ($urandom_range(0, 9))
                6, 7: put_escape(8'($urandom_range(1, 255)));
                8: begin
                    url_bytes.push_back(CH_PCT);
                    url_bytes.push_back(8'($urandom_range(1, 255)));
                    url_bytes.push_back(8'($urandom_range(1, 255)));
                end
                9: url_bytes.push_back(8'($urandom_range(128, 255)));
                default: begin
                    do c = 8'($urandom_range(33, 126)); while (c == CH_PCT);
                    url_bytes.push_back(c);
                end
            endcase
        end
    endfunction

    // prefix, path, optional query, sometimes a broken tail
    function automatic void build_url();
        int n_args;
        url_bytes.delete();
        repeat ($urandom_range(0, 3)) url_bytes.push_back(8'($urandom_range(97, 122)));
        url_bytes.push_back(CH_SLASH);
        put_content($urandom_range(0, 8));
        if ($urandom_range(0, 3) != 0) begin
            url_bytes.push_back(CH_QMARK);
            n_args = $urandom_range(1, 3);
            for (int a = 0; a < n_args; a++) begin
                if (a > 0) begin
                    url_bytes.push_back(CH_AMP);
                end
                put_content($urandom_range(0, 5));
                url_bytes.push_back(CH_EQ);
                put_content($urandom_range(0, 6));
            end
        end
        case ($urandom_range(0, 7))
            0: url_bytes.push_back(CH_PCT);
            1: begin
                url_bytes.push_back(CH_PCT);
                url_bytes.push_back(hex_digit(4'($urandom_range(0, 15))));
            end
            2: begin
                url_bytes.push_back(CH_NUL);
                put_content($urandom_range(1, 3));
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        // encoded slash in path, encoded '?' as delimiter, string ends in name
        send_text("q/%2F%3f", 1'b1);
        // bad hex, 0xFF, encoded NUL ends the string, bytes after end
        send_text("/%zQ=%FF&%00x", 1'b1);
        // raw NUL with nothing open, then last with nothing to report
        send_url_byte(CH_NUL, 1'b0);
        send_url_byte(8'hFF, 1'b1);
        // escape cut short by last
        send_text("/%4", 1'b1);
    endtask

    task automatic test_length_limit();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        url_bytes.delete();
        url_bytes.push_back(CH_SLASH);
        repeat (MAX_DECODED + 8) begin
            if ($urandom_range(0, 3) == 0) begin
                put_escape(8'($urandom_range(97, 122)));
            end else begin
                url_bytes.push_back(8'($urandom_range(97, 122)));
            end
        end
        send_url();
    endtask

    task automatic test_backpressure();
        int stop_at;
        tx_idle   = 1'b0;
        rx_idle   = 1'b0;
        long_hold = 150;
        stop_at   = n_sent + 40;
        while (n_sent < stop_at) begin
            build_url();
            send_url();
        end
    endtask

    task automatic test_random_urls();
        int stop_at;
        int n;
        stop_at = n_sent + 180;
        while (n_sent < stop_at) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 24);
                for (int i = 0; i < n; i++) begin
                    send_url_byte(8'($urandom_range(0, 255)), $urandom_range(0, 11) == 0);
                end
            end else begin
                build_url();
                send_url();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // receiver
    // ------------------------------------------------------------------------
    initial begin
        int hold;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            hold = rx_idle ? $urandom_range(0, 17) : 0;
            if (long_hold > 0) begin
                hold      = long_hold;
                long_hold = 0;
            end
            if (hold > 0) begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (hold - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    always @(posedge clk) begin : check_tokens
        t_res want;
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            if (tokens_due.size() == 0) begin
                n_fail++;
                if (n_fail <= 10) begin
                    $display("%0t: unexpected result %p", $realtime, out_data);
                end
            end else begin
                want = tokens_due.pop_front();
                if (out_data.token_kind !== want.token_kind ||
                    out_data.is_char !== want.is_char ||
                    out_data.out_char !== want.out_char ||
                    out_data.token_end !== want.token_end ||
                    out_data.end_of_string !== want.end_of_string) begin
                    n_fail++;
                    if (n_fail <= 10) begin
                        $display("%0t: expected %p, got %p", $realtime, want, out_data);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int waited;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_length_limit();
        test_backpressure();
        test_random_urls();

        @(negedge clk);
        in_valid <= 1'b0;
        waited = 0;
        while (tokens_due.size() != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (n_fail == 0 && tokens_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
